// ===== hw/rtl/ssp_pkg.sv =====
// Shared types and constants for the sinusoidal sky projection block.
// Depends on nothing; used by every module under hw/rtl.
`timescale 1ns / 1ps
package ssp_pkg;

  // Result codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_THETA_LOW  = 3'd0;
  localparam logic [2:0] REG_THETA_HIGH = 3'd1;
  localparam logic [2:0] REG_PHI_LOW    = 3'd2;
  localparam logic [2:0] REG_PHI_HIGH   = 3'd3;
  localparam logic [2:0] REG_WIDTH      = 3'd4;
  localparam logic [2:0] REG_HEIGHT     = 3'd5;

  localparam logic [63:0] PI_X60 = 64'h3243F6A8885A308D;
  localparam int ATAN_COUNT = 30;
  localparam logic [31:0] CORDIC_START = 32'd652032874;
  localparam logic [31:0] ONE_Q30 = 32'd1073741824;

  // Divider quotient widths
  localparam int QW = 32;

  // atan(2^-i) in Q30
  function automatic logic [29:0] atan_q30(input int i);
    logic [29:0] r;
    r = 30'd0;
    case (i)
      0: r = 30'd843314857;
      1: r = 30'd497837829;
      2: r = 30'd263043837;
      3: r = 30'd133525159;
      4: r = 30'd67021687;
      5: r = 30'd33543516;
      6: r = 30'd16775851;
      7: r = 30'd8388437;
      8: r = 30'd4194283;
      9: r = 30'd2097149;
      default: r = (i < 30) ? (30'd1 << (30 - i)) : 30'd0;
    endcase
    return r;
  endfunction

  // Payload traveling down the CORDIC row (one set per direction)
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } cordic_t;

  // Payload traveling down the divider row
  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] den;
    logic [QW-1:0] quo;
  } div_t;

endpackage

// ===== hw/rtl/ssp_cordic_cell.sv =====
// One rotation step of the cosine CORDIC row.
// Depends on ssp_pkg.
`timescale 1ns / 1ps
module ssp_cordic_cell
  import ssp_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic    clk,
  input  cordic_t a_in,
  output cordic_t a_out
);
  localparam int SH = (STEP < 33) ? STEP : 33;
  cordic_t n_nxt;
  cordic_t n_r;

  // Rotate toward zero residual angle
  always_comb begin
    if (STEP >= ATAN_COUNT) begin
      n_nxt = a_in;
    end else if (!a_in.z[33]) begin
      n_nxt.x = a_in.x - (a_in.y >>> SH);
      n_nxt.y = a_in.y + (a_in.x >>> SH);
      n_nxt.z = a_in.z - $signed({4'd0, atan_q30(STEP)});
    end else begin
      n_nxt.x = a_in.x + (a_in.y >>> SH);
      n_nxt.y = a_in.y - (a_in.x >>> SH);
      n_nxt.z = a_in.z + $signed({4'd0, atan_q30(STEP)});
    end
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt;
  end
  assign a_out = n_r;
endmodule

// ===== hw/rtl/ssp_div_cell.sv =====
// One restoring-division step: one quotient bit per cell.
// Depends on ssp_pkg.
`timescale 1ns / 1ps
module ssp_div_cell
  import ssp_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic clk,
  input  div_t d_in,
  output div_t d_out
);
  div_t n_nxt;
  div_t n_r;
  logic [95:0] sub;

  // Compare remainder against den shifted to this bit
  always_comb begin
    sub = {32'd0, d_in.rem} - ({64'd0, d_in.den} << BIT);
    n_nxt = d_in;
    if (!sub[95]) begin
      n_nxt.rem = sub[63:0];
      n_nxt.quo[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt;
  end
  assign d_out = n_r;
endmodule

// ===== hw/rtl/sinusoidal_sky_projection.sv =====
// Top level of the sinusoidal sky projection: front end, CORDIC rows, divider rows.
// Depends on ssp_pkg, ssp_cordic_cell, ssp_div_cell.
//
//  channel | ports                          | handshake
//  input   | in_colatitude, in_longitude    | start & !busy
//  result  | out_x_pos, out_y_pos, out_status | out_valid, one cycle
//  config  | cfg_we, cfg_index, cfg_data    | cfg_we
//
// One direction enters every clock; busy is always low. out_valid rises after the
// front stage, CORDIC rows, products, window test, divider seed, two 32-cell
// divider rows (x and y side by side) and the output register. Reset clears only
// the valid pipeline and the registers. The receiver cannot stall; results leave
// on out_valid.
`timescale 1ns / 1ps
module sinusoidal_sky_projection
  import ssp_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 28,
  parameter int SINE_ITERATIONS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [29:0] in_colatitude,
  input  logic [30:0] in_longitude,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  output logic [31:0] out_x_pos,
  output logic [31:0] out_y_pos,
  output logic [1:0]  out_status
);
  localparam logic [63:0] PI_Q =
    (PI_X60 + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS);
  localparam logic [63:0] TWO_PI_Q =
    (PI_X60 + (64'd1 << (58 - ANGLE_FRAC_BITS))) >> (59 - ANGLE_FRAC_BITS);
  localparam int ZSH = 29 - ANGLE_FRAC_BITS;
  localparam int NC = SINE_ITERATIONS;
  // stage counts: S0 front, cordic NC, S1 mult, S2 norm, div seed + 32 cells, S3 out
  localparam int LAT = NC + QW + 4;

  // Configuration registers
  logic [29:0] tl_r, th_r;
  logic [30:0] pl_r, ph_r;
  logic [31:0] wpx_r, hpx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tl_r  <= '0;
      th_r  <= PI_Q[29:0];
      pl_r  <= '0;
      ph_r  <= TWO_PI_Q[30:0];
      wpx_r <= 32'd16777216;
      hpx_r <= 32'd16777216;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THETA_LOW:  tl_r  <= cfg_data[29:0];
        REG_THETA_HIGH: th_r  <= cfg_data[29:0];
        REG_PHI_LOW:    pl_r  <= cfg_data[30:0];
        REG_PHI_HIGH:   ph_r  <= cfg_data[30:0];
        REG_WIDTH:      wpx_r <= cfg_data;
        REG_HEIGHT:     hpx_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;
  logic acc;
  assign acc = start & ~busy;

  // ---- Stage 0: range checks, offsets, CORDIC seeds ----
  logic [1:0]         st0_nxt;
  logic signed [33:0] d2_nxt;
  logic [31:0]        span_nxt;
  logic [29:0]        ynum_nxt;
  cordic_t            ch_nxt, co_nxt;
  logic signed [33:0] c2w, d2w;
  logic signed [33:0] tpq, pq;

  always_comb begin
    tpq = $signed({3'd0, TWO_PI_Q[30:0]});
    pq  = $signed({4'd0, PI_Q[29:0]});
    st0_nxt = ST_OK;
    if ({34'd0, tl_r} > PI_Q || {34'd0, th_r} > PI_Q || {33'd0, pl_r} > TWO_PI_Q
        || {33'd0, ph_r} > TWO_PI_Q || th_r <= tl_r || ph_r == pl_r
        || {34'd0, in_colatitude} > PI_Q || {33'd0, in_longitude} > TWO_PI_Q)
      st0_nxt = ST_RANGE;
    else if (in_colatitude < tl_r || in_colatitude > th_r)
      st0_nxt = ST_OUTSIDE;
    if (ph_r > pl_r) begin
      span_nxt = {1'b0, ph_r} - {1'b0, pl_r};
      c2w = $signed({3'd0, ph_r}) + $signed({3'd0, pl_r});
      d2w = $signed({2'd0, in_longitude, 1'b0}) - c2w;
    end else begin
      span_nxt = {1'b0, ph_r} + {1'b0, TWO_PI_Q[30:0]} - {1'b0, pl_r};
      c2w = $signed({3'd0, ph_r}) + $signed({3'd0, pl_r}) + tpq;
      if (c2w >= 2 * tpq) c2w = c2w - 2 * tpq;
      d2w = $signed({2'd0, in_longitude, 1'b0}) - c2w;
      if (d2w > tpq) d2w = d2w - 2 * tpq;
      else if (d2w <= -tpq) d2w = d2w + 2 * tpq;
    end
    d2_nxt = d2w;
    ynum_nxt = th_r - in_colatitude;
    ch_nxt.x = $signed({2'd0, CORDIC_START});
    ch_nxt.y = '0;
    ch_nxt.z = ($signed({4'd0, tl_r}) + $signed({4'd0, th_r}) - pq) <<< ZSH;
    co_nxt.x = $signed({2'd0, CORDIC_START});
    co_nxt.y = '0;
    co_nxt.z = ($signed({3'd0, in_colatitude, 1'b0}) - pq) <<< ZSH;
  end

  // Side pipeline carrying per-item fields alongside the CORDIC row
  logic [NC:0]        v_r;
  logic [1:0]         st_r   [NC+1];
  logic signed [33:0] d2_r   [NC+1];
  logic [31:0]        span_r [NC+1];
  logic [29:0]        yn_r   [NC+1];
  cordic_t            ch_c   [NC+1];
  cordic_t            co_c   [NC+1];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else v_r <= {v_r[NC-1:0], acc};
  end

  always_ff @(posedge clk) begin
    st_r[0] <= st0_nxt;
    d2_r[0] <= d2_nxt;
    span_r[0] <= span_nxt;
    yn_r[0] <= ynum_nxt;
    ch_c[0] <= ch_nxt;
    co_c[0] <= co_nxt;
    for (int i = 1; i <= NC; i++) begin
      st_r[i] <= st_r[i-1];
      d2_r[i] <= d2_r[i-1];
      span_r[i] <= span_r[i-1];
      yn_r[i] <= yn_r[i-1];
    end
  end

  // CORDIC rows: one cell per iteration, both sines in parallel
  for (genvar g = 0; g < NC; g++) begin : g_cordic
    ssp_cordic_cell #(.STEP(g)) u_h (.clk(clk), .a_in(ch_c[g]), .a_out(ch_c[g+1]));
    ssp_cordic_cell #(.STEP(g)) u_o (.clk(clk), .a_in(co_c[g]), .a_out(co_c[g+1]));
  end

  // ---- Stage 1: clamp sines, products ----
  logic [30:0] sh_w, so_w;
  always_comb begin
    sh_w = ch_c[NC].x[33] ? 31'd0 :
           (ch_c[NC].x > $signed({2'd0, ONE_Q30})) ? ONE_Q30[30:0] : ch_c[NC].x[30:0];
    so_w = co_c[NC].x[33] ? 31'd0 :
           (co_c[NC].x > $signed({2'd0, ONE_Q30})) ? ONE_Q30[30:0] : co_c[NC].x[30:0];
  end

  logic               v1_r;
  logic [1:0]         st1_r;
  logic [63:0]        half1_r;
  logic signed [65:0] off1_r;
  logic [29:0]        yn1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= v_r[NC];
    st1_r   <= st_r[NC];
    half1_r <= span_r[NC] * {1'b0, sh_w};
    off1_r  <= d2_r[NC] * $signed({1'b0, so_w});
    yn1_r   <= yn_r[NC];
  end

  // ---- Stage 2: window test, normalize x fraction ----
  logic [1:0]  st2_nxt;
  logic [65:0] num_w;
  logic [65:0] den_w;
  logic [31:0] xn_nxt, xd_nxt;
  logic signed [66:0] hs;
  logic        found;
  always_comb begin
    hs = $signed({3'd0, half1_r});
    st2_nxt = st1_r;
    if (st1_r == ST_OK &&
        (half1_r == 64'd0 || off1_r > hs || off1_r < -hs))
      st2_nxt = ST_OUTSIDE;
    num_w = off1_r[65:0] + {2'd0, half1_r};
    den_w = {1'b0, half1_r, 1'b0};
    // highest set bit of den picks the shift leaving den below 2^31
    xn_nxt = num_w[31:0];
    xd_nxt = den_w[31:0];
    found = 1'b0;
    for (int s = 35; s >= 1; s--) begin
      if (!found && den_w[30+s]) begin
        found = 1'b1;
        xn_nxt = 32'(num_w >> s);
        xd_nxt = 32'(den_w >> s);
      end
    end
  end

  logic        v2_r;
  logic [1:0]  st2_r;
  logic [31:0] xn2_r, xd2_r;
  logic [29:0] yn2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
    st2_r <= st2_nxt;
    xn2_r <= xn_nxt;
    xd2_r <= xd_nxt;
    yn2_r <= yn1_r;
  end

  // Both divisions run through their own 32-cell rows
  div_t dx_c [QW+1];
  div_t dy_c [QW+1];
  logic [QW:0] vd_r;
  logic [1:0]  std_r [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) vd_r <= '0;
    else vd_r <= {vd_r[QW-1:0], v2_r};
    std_r[0] <= st2_r;
    for (int i = 1; i <= QW; i++) std_r[i] <= std_r[i-1];
    dx_c[0].rem <= wpx_r * xn2_r + {33'd0, xd2_r[31:1]};
    dx_c[0].den <= (xd2_r == 32'd0) ? 32'd1 : xd2_r;
    dx_c[0].quo <= '0;
    dy_c[0].rem <= yn2_r * hpx_r + {34'd0, (th_r - tl_r) >> 1};
    dy_c[0].den <= {2'd0, th_r - tl_r};
    dy_c[0].quo <= '0;
  end

  for (genvar g = 0; g < QW; g++) begin : g_div
    ssp_div_cell #(.BIT(QW-1-g)) u_x (.clk(clk), .d_in(dx_c[g]), .d_out(dx_c[g+1]));
    ssp_div_cell #(.BIT(QW-1-g)) u_y (.clk(clk), .d_in(dy_c[g]), .d_out(dy_c[g+1]));
  end

  // ---- Output register ----
  logic        ov_r;
  logic [31:0] ox_r, oy_r;
  logic [1:0]  os_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else ov_r <= vd_r[QW];
    os_r <= std_r[QW];
    ox_r <= (std_r[QW] == ST_OK) ? dx_c[QW].quo : 32'd0;
    oy_r <= (std_r[QW] == ST_OK) ? dy_c[QW].quo : 32'd0;
  end

  assign out_valid  = ov_r;
  assign out_x_pos  = ox_r;
  assign out_y_pos  = oy_r;
  assign out_status = os_r;

  // Every accepted request shows up as a result on out_valid
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##(LAT+1) ov_r) else $error("lost request");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && out_status != ST_OK |-> out_x_pos == 32'd0 && out_y_pos == 32'd0)
    else $error("nonzero position on failed request");
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> out_status != 2'd3) else $error("bad status");
  a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
endmodule

// ===== tb/sinusoidal_sky_projection_test.sv =====
// Testbench for sinusoidal_sky_projection: directed and random directions through several
// window settings, each result checked against a built-in fixed-point projection model.
// Depends on ssp_pkg and the sinusoidal_sky_projection RTL.
`timescale 1ns / 1ps
module sinusoidal_sky_projection_test
  import ssp_pkg::*;
();

  localparam int FRAC = 28;
  localparam int SINE_STEPS = 24;
  localparam int LATENCY = SINE_STEPS + 36;
  localparam int WATCHDOG_LIMIT = 20 * LATENCY + 2000;
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;
  localparam longint PI_FX = longint'((PI_X60 + (64'd1 << (59 - FRAC))) >> (60 - FRAC));
  localparam longint TWO_PI_FX = longint'((PI_X60 + (64'd1 << (58 - FRAC))) >> (59 - FRAC));
  localparam longint CORDIC_X0 = 652032874;
  localparam longint UNIT_Q30 = 1073741824;

  typedef struct packed {
    logic [31:0] x_pos;
    logic [31:0] y_pos;
    logic [1:0]  status;
  } point_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [29:0] in_colatitude = '0;
  logic [30:0] in_longitude = '0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        out_valid;
  logic [31:0] out_x_pos;
  logic [31:0] out_y_pos;
  logic [1:0]  out_status;

  // Model copy of the window registers
  longint unsigned m_tl, m_th, m_pl, m_ph, m_w, m_h;

  point_t pending_points[$];
  int     mismatches = 0;
  int     quiet_cycles = 0;
  logic   busy_seen = 1'b0;
  bit     idling_on = 1'b1;
  longint arctan_q30[30] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
    131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
    128, 64, 32, 16, 8, 4, 2};

  sinusoidal_sky_projection dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_colatitude(in_colatitude), .in_longitude(in_longitude),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_x_pos(out_x_pos), .out_y_pos(out_y_pos),
    .out_status(out_status)
  );

  always #5 clk = ~clk;

  // CORDIC cosine, Q30 in, Q30 out clamped to [0, 1]
  function automatic longint cordic_cos(longint z);
    longint x, y, dx, dy;
    x = CORDIC_X0;
    y = 0;
    for (int i = 0; i < SINE_STEPS && i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_q30[i];
      end else begin
        x += dx; y -= dy; z += arctan_q30[i];
      end
    end
    if (x < 0) x = 0;
    if (x > UNIT_Q30) x = UNIT_Q30;
    return x;
  endfunction

  // sin of an angle given doubled
  function automatic longint sine_of_doubled(longint a2);
    return cordic_cos((a2 - PI_FX) * (longint'(1) << (29 - FRAC)));
  endfunction

  function automatic point_t project_point(logic [29:0] colat, logic [30:0] lon);
    point_t r;
    longint t, p, tl, th, pl, ph, span, c2, d2, half2, off2;
    longint unsigned ypos, num, den, xpos;
    t = colat; p = lon;
    tl = m_tl; th = m_th; pl = m_pl; ph = m_ph;
    r = '{x_pos: '0, y_pos: '0, status: ST_RANGE};
    if (tl > PI_FX || th > PI_FX || pl > TWO_PI_FX || ph > TWO_PI_FX ||
        th <= tl || ph == pl || t > PI_FX || p > TWO_PI_FX)
      return r;
    r.status = ST_OUTSIDE;
    if (t < tl || t > th) return r;
    den = th - tl;
    ypos = ((th - t) * m_h + den / 2) / den;
    if (ph > pl) begin
      span = ph - pl;
      c2 = ph + pl;
      d2 = 2 * p - c2;
    end else begin
      // window wraps through zero longitude
      span = ph + TWO_PI_FX - pl;
      c2 = pl + ph + TWO_PI_FX;
      if (c2 >= 2 * TWO_PI_FX) c2 -= 2 * TWO_PI_FX;
      d2 = 2 * p - c2;
      if (d2 > TWO_PI_FX) d2 -= 2 * TWO_PI_FX;
      else if (d2 <= -TWO_PI_FX) d2 += 2 * TWO_PI_FX;
    end
    half2 = span * sine_of_doubled(tl + th);
    off2 = d2 * sine_of_doubled(2 * t);
    if (half2 <= 0 || off2 > half2 || off2 < -half2) return r;
    num = off2 + half2;
    den = longint'(half2) * 2;
    while (den >= (64'd1 << 31)) begin
      num >>= 1;
      den >>= 1;
    end
    xpos = (m_w * num + den / 2) / den;
    r.x_pos = xpos[31:0];
    r.y_pos = ypos[31:0];
    r.status = ST_OK;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Result checker, sampled away from the active edge
  always @(negedge clk) begin
    point_t want;
    busy_seen <= busy;
    if (rst_n && out_valid) begin
      quiet_cycles = 0;
      if (pending_points.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        mismatches++;
      end else begin
        want = pending_points.pop_front();
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_x_pos !== want.x_pos) report_mismatch("x_pos", out_x_pos, want.x_pos);
        if (out_y_pos !== want.y_pos) report_mismatch("y_pos", out_y_pos, want.y_pos);
      end
    end
  end

  // Watchdog on cycles with no traffic
  always @(posedge clk) begin
    quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** sinusoidal_sky_projection: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_THETA_LOW:  m_tl = val[29:0];
      REG_THETA_HIGH: m_th = val[29:0];
      REG_PHI_LOW:    m_pl = val[30:0];
      REG_PHI_HIGH:   m_ph = val[30:0];
      REG_WIDTH:      m_w = val;
      REG_HEIGHT:     m_h = val;
      default: ;
    endcase
  endtask

  // Let the pipe drain before touching the registers
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_window(longint tl, longint th, longint pl, longint ph,
                            logic [31:0] w, logic [31:0] h);
    wait_drained();
    write_reg(REG_THETA_LOW, tl[31:0]);
    write_reg(REG_THETA_HIGH, th[31:0]);
    write_reg(REG_PHI_LOW, pl[31:0]);
    write_reg(REG_PHI_HIGH, ph[31:0]);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // Send one direction request; start held across back-to-back requests
  task automatic send_direction(longint colat, longint lon);
    if (idling_on && $urandom_range(99) < 38) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    start <= 1'b1;
    in_colatitude <= colat[29:0];
    in_longitude <= lon[30:0];
    do @(posedge clk); while (busy_seen);
    quiet_cycles = 0;
    pending_points.push_back(project_point(colat[29:0], lon[30:0]));
  endtask

  function automatic longint pick(longint lo, longint hi);
    longint unsigned r;
    r = {$urandom, $urandom};
    return lo + longint'(r % longint'(hi - lo + 1));
  endfunction

  task automatic test_directed();
    set_window(0, PI_FX, 0, TWO_PI_FX, 32'h0100_0000, 32'h0100_0000);
    // poles, equator, longitude extremes
    send_direction(0, 0);
    send_direction(PI_FX, TWO_PI_FX);
    send_direction(PI_FX / 2, PI_FX);
    send_direction(PI_FX / 2, 0);
    send_direction(PI_FX / 2, TWO_PI_FX);
    // input range errors
    send_direction(30'h3FFF_FFFF, 31'h7FFF_FFFF);
    send_direction(PI_FX + 1, 5);
    send_direction(7, TWO_PI_FX + 1);
    // narrow window, points inside it and outside in colatitude and longitude
    set_window(PI_FX / 4, PI_FX / 2, PI_FX / 2, PI_FX, 32'h0000_0001, 32'hFFFF_FFFF);
    send_direction(PI_FX / 4 - 1, 3 * PI_FX / 4);
    send_direction(PI_FX / 2 + 1, 3 * PI_FX / 4);
    send_direction(3 * PI_FX / 8, 3 * PI_FX / 4);
    send_direction(3 * PI_FX / 8, PI_FX / 2);
    send_direction(3 * PI_FX / 8, 0);
    // wrapping window through zero longitude
    set_window(0, PI_FX, 3 * PI_FX / 2, PI_FX / 2, 32'hFFFF_FFFF, 32'h0000_8000);
    send_direction(PI_FX / 3, 0);
    send_direction(PI_FX / 3, TWO_PI_FX);
    send_direction(PI_FX / 3, PI_FX);
    send_direction(PI_FX / 3, PI_FX / 4);
    // zero half width: window centered on a pole
    set_window(0, 1, 0, TWO_PI_FX, 32'h0001_0000, 32'h0001_0000);
    send_direction(0, 10);
    send_direction(1, PI_FX);
    // register range errors
    set_window(5, 5, 0, TWO_PI_FX, 32'h0100_0000, 32'h0100_0000);
    send_direction(5, 5);
    set_window(0, PI_FX, 9, 9, 32'h0100_0000, 32'h0100_0000);
    send_direction(3, 9);
    set_window(PI_FX + 1, 30'h3FFF_FFFF, 31'h7FFF_FFFF, 0, 32'h0100_0000, 32'h0100_0000);
    send_direction(PI_FX, 0);
    // writes to spare indexes change nothing
    set_window(0, PI_FX, 0, TWO_PI_FX, 32'h0100_0000, 32'h0100_0000);
    write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_B, 32'h0000_0000);
    send_direction(PI_FX / 2, PI_FX / 3);
  endtask

  // Random well-formed windows, with directions mostly inside their colatitude range
  task automatic test_random_windows(int phases, int per_phase);
    longint tl, th, pl, ph, t, p;
    logic [31:0] w, h;
    for (int k = 0; k < phases; k++) begin
      tl = pick(0, PI_FX - 2);
      th = pick(tl + 1, PI_FX);
      pl = pick(0, TWO_PI_FX);
      ph = pick(0, TWO_PI_FX);
      if (ph == pl) ph = (pl == 0) ? 1 : pl - 1;
      case (k % 4)
        0: begin w = $urandom_range(32'h0001_0000, 32'h0400_0000); h = $urandom; end
        1: begin w = 32'hFFFF_FFFF; h = 32'h0001_0000; end
        2: begin w = $urandom; h = 32'hFFFF_FFFF; end
        default: begin w = $urandom_range(1, 32'hFFFF); h = $urandom_range(1, 32'hFFFF); end
      endcase
      if (k == phases - 1) begin
        // wide window at the extremes
        tl = 0; th = PI_FX; pl = TWO_PI_FX; ph = 0;
      end
      set_window(tl, th, pl, ph, w, h);
      idling_on = (k != 1);
      for (int n = 0; n < per_phase; n++) begin
        if ($urandom_range(99) < 85) begin
          t = pick(tl, th);
          p = pick(0, TWO_PI_FX);
        end else begin
          t = {$urandom} & 32'h3FFF_FFFF;
          p = {$urandom} & 32'h7FFF_FFFF;
        end
        send_direction(t, p);
        if (n == per_phase / 2 && k == 2) wait_drained();
      end
    end
    idling_on = 1'b1;
  endtask

  initial begin
    m_tl = 0; m_th = PI_FX; m_pl = 0; m_ph = TWO_PI_FX;
    m_w = 32'h0100_0000; m_h = 32'h0100_0000;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // reset values first
    send_direction(PI_FX / 2, PI_FX / 2);
    send_direction(PI_FX / 5, 3 * PI_FX / 2);
    test_directed();
    test_random_windows(8, 55);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("** sinusoidal_sky_projection: PASSED **");
    end else begin
      $display("** sinusoidal_sky_projection: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ssp_pkg.sv
hw/rtl/ssp_cordic_cell.sv
hw/rtl/ssp_div_cell.sv
hw/rtl/sinusoidal_sky_projection.sv
tb/sinusoidal_sky_projection_test.sv
